FILE: rtl/core/cylinder_region_histogram_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for cylinder_region_histogram
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CYLINDER_REGION_HISTOGRAM_DEFINES_SVH
`define CYLINDER_REGION_HISTOGRAM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRH_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/crh_pkg.sv
// ----------------------------------------------------------------------------
// crh_pkg
// Types, register indexes, function codes and reset values of the
// cylinder region histogram.
// ----------------------------------------------------------------------------
package crh_pkg;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 43;

	localparam logic [CFG_AW-1:0] REG_LOW_Z     = 3'd0;
	localparam logic [CFG_AW-1:0] REG_UP_Z      = 3'd1;
	localparam logic [CFG_AW-1:0] REG_CENTER_X  = 3'd2;
	localparam logic [CFG_AW-1:0] REG_CENTER_Y  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_RADIUS_SQ = 3'd4;
	localparam logic [CFG_AW-1:0] REG_BIN_SCALE = 3'd5;
	localparam logic [CFG_AW-1:0] REG_BINS_USED = 3'd6;

	localparam logic FUNC_ACCUM = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	localparam logic signed [19:0] RST_LOW_Z     = 20'sd31789;
	localparam logic signed [19:0] RST_UP_Z      = 20'sd50131;
	localparam logic signed [19:0] RST_CENTER_X  = 20'sd11588;
	localparam logic signed [19:0] RST_CENTER_Y  = 20'sd8421;
	localparam logic [42:0]        RST_RADIUS_SQ = 43'd14417209;
	localparam logic [31:0]        RST_BIN_SCALE = 32'd91468;
	localparam logic [8:0]         RST_BINS_USED = 9'd100;

	typedef struct packed {
		logic signed [19:0] low_z;
		logic signed [19:0] up_z;
		logic signed [19:0] center_x;
		logic signed [19:0] center_y;
		logic [42:0]        radius_sq;
		logic [31:0]        bin_scale;
		logic [8:0]         bins_used;
	} cfg_t;

	typedef struct packed {
		logic               func;
		logic signed [19:0] pos_x;
		logic signed [19:0] pos_y;
		logic signed [19:0] pos_z;
		logic [7:0]         read_bin;
	} item_t;

	// Geometry stage results: squared axis distances and the scaled z offset.
	typedef struct packed {
		logic        func;
		logic [7:0]  read_bin;
		logic        z_in;
		logic [39:0] sq_x;
		logic [39:0] sq_y;
		logic [51:0] prod;
	} geo_t;

	// Control of the count update stage.
	typedef struct packed {
		logic       is_read;
		logic       hit;
		logic       oob;
		logic [7:0] bin_hit;
	} upd_ctl_t;

endpackage

FILE: rtl/core/crh_ram.sv
// ----------------------------------------------------------------------------
// crh_ram
// Generic single write port RAM with one registered read port. A read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module crh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/crh_filter.sv
// ----------------------------------------------------------------------------
// crh_filter
// Geometry stage: axis distance squares, z slab test and the scaled z offset,
// registered into the second pipeline stage.
// ----------------------------------------------------------------------------
module crh_filter (
	input  logic          clk,
	input  logic          load,
	input  crh_pkg::item_t item,
	input  crh_pkg::cfg_t  cfg,
	output crh_pkg::geo_t  geo_s2
);

	logic signed [20:0] dx;
	logic signed [20:0] dy;
	logic signed [20:0] dz;
	logic signed [41:0] sq_x_full;
	logic signed [41:0] sq_y_full;
	logic [51:0]        prod;
	logic               z_in;

	always_comb begin
		dx = 21'(item.pos_x) - 21'(cfg.center_x);
		dy = 21'(item.pos_y) - 21'(cfg.center_y);
		dz = 21'(item.pos_z) - 21'(cfg.low_z);
		sq_x_full = dx * dx;
		sq_y_full = dy * dy;
		z_in = (item.pos_z >= cfg.low_z) && (item.pos_z < cfg.up_z);
		// Inside the slab the offset is non-negative and fits in 20 bits.
		prod = 52'(dz[19:0]) * 52'(cfg.bin_scale);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			geo_s2.func     <= item.func;
			geo_s2.read_bin <= item.read_bin;
			geo_s2.z_in     <= z_in;
			geo_s2.sq_x     <= sq_x_full[39:0];
			geo_s2.sq_y     <= sq_y_full[39:0];
			geo_s2.prod     <= prod;
		end
	end

endmodule

FILE: rtl/core/crh_update.sv
// ----------------------------------------------------------------------------
// crh_update
// Count update stage: write forwarding, saturating increment, histogram
// write and the result register.
// ----------------------------------------------------------------------------
module crh_update #(
	parameter int AW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  crh_pkg::upd_ctl_t ctl,
	input  logic [AW-1:0]     addr,
	input  logic [31:0]       rd_data,
	output logic              we,
	output logic [AW-1:0]     waddr,
	output logic [31:0]       wdata,
	output logic              in_region,
	output logic [7:0]        bin_hit,
	output logic [31:0]       count_value
);

	logic          fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	logic [31:0]   fwd_data_q;
	logic [31:0]   cur;
	logic [31:0]   nxt;

	// The forward register holds the most recent histogram write, which is
	// always what the memory holds at that address.
	always_comb begin
		cur = (fwd_valid_q && (fwd_addr_q == addr)) ? fwd_data_q : rd_data;
		nxt = (cur == 32'hFFFF_FFFF) ? cur : cur + 32'd1;
		we = advance && ctl.hit;
		waddr = addr;
		wdata = nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			fwd_addr_q <= addr;
			fwd_data_q <= nxt;
		end
		if (advance) begin
			in_region <= ctl.hit;
			bin_hit   <= ctl.bin_hit;
			if (ctl.is_read) begin
				count_value <= ctl.oob ? 32'd0 : cur;
			end else begin
				count_value <= ctl.hit ? nxt : 32'd0;
			end
		end
	end

endmodule

FILE: rtl/core/cylinder_region_histogram.sv
// ----------------------------------------------------------------------------
// cylinder_region_histogram
// Histogram of particle z positions inside a cylindrical slab, with bin
// read-back.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     func, pos_x, pos_y, pos_z, read_bin
// out       output     out_valid / out_ready   in_region, bin_hit, count_value
// cfg       input      cfg_we (no wait)        cfg_addr, cfg_wdata
//
// One item is accepted per cycle while in_ready is high. An item passes the
// input, geometry, memory-read and result registers; the input register
// loads at the accepting edge. After reset a clearing pass zeroes every
// histogram memory entry, during which in_ready is low; configuration
// writes are taken as always. A stalled output holds only the stages behind
// it that are full, so empty stages keep accepting items.
//
`include "cylinder_region_histogram_defines.svh"

module cylinder_region_histogram #(
	parameter int MAX_BINS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [crh_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [crh_pkg::CFG_DW-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic signed [19:0]          pos_x,
	input  logic signed [19:0]          pos_y,
	input  logic signed [19:0]          pos_z,
	input  logic [7:0]                  read_bin,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        in_region,
	output logic [7:0]                  bin_hit,
	output logic [31:0]                 count_value
);

	localparam int AW = $clog2(MAX_BINS);

	// Configuration registers.
	crh_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_z     <= crh_pkg::RST_LOW_Z;
			cfg_q.up_z      <= crh_pkg::RST_UP_Z;
			cfg_q.center_x  <= crh_pkg::RST_CENTER_X;
			cfg_q.center_y  <= crh_pkg::RST_CENTER_Y;
			cfg_q.radius_sq <= crh_pkg::RST_RADIUS_SQ;
			cfg_q.bin_scale <= crh_pkg::RST_BIN_SCALE;
			cfg_q.bins_used <= crh_pkg::RST_BINS_USED;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				crh_pkg::REG_LOW_Z:     cfg_q.low_z     <= cfg_wdata[19:0];
				crh_pkg::REG_UP_Z:      cfg_q.up_z      <= cfg_wdata[19:0];
				crh_pkg::REG_CENTER_X:  cfg_q.center_x  <= cfg_wdata[19:0];
				crh_pkg::REG_CENTER_Y:  cfg_q.center_y  <= cfg_wdata[19:0];
				crh_pkg::REG_RADIUS_SQ: cfg_q.radius_sq <= cfg_wdata[42:0];
				crh_pkg::REG_BIN_SCALE: cfg_q.bin_scale <= cfg_wdata[31:0];
				crh_pkg::REG_BINS_USED: cfg_q.bins_used <= cfg_wdata[8:0];
				default: begin
				end
			endcase
		end
	end

	// Clearing pass: one histogram entry is zeroed per cycle after reset.
	logic          clr_active_q;
	logic [AW-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			if (clr_idx_q == AW'(MAX_BINS - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + AW'(1);
		end
	end

	// Pipeline flow control. Each stage loads when it is empty or when the
	// stage ahead of it takes its item, so bubbles are squeezed out while the
	// result register waits.
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic out_valid_q;
	logic out_free;
	logic en1;
	logic en2;
	logic en3;
	logic mv1;
	logic mv2;
	logic adv3;
	logic accept;
	logic pipe_busy;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		en3 = !valid_s3 || out_free;
		en2 = !valid_s2 || en3;
		en1 = !valid_s1 || en2;
		adv3 = valid_s3 && out_free;
		mv2 = valid_s2 && en3;
		mv1 = valid_s1 && en2;
		in_ready = en1 && !clr_active_q;
		accept = in_valid && in_ready;
		pipe_busy = valid_s1 || valid_s2 || valid_s3 || out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= accept;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (out_free) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	assign out_valid = out_valid_q;

	// Stage 1: input register.
	crh_pkg::item_t item_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.func     <= func;
			item_s1.pos_x    <= pos_x;
			item_s1.pos_y    <= pos_y;
			item_s1.pos_z    <= pos_z;
			item_s1.read_bin <= read_bin;
		end
	end

	// Stage 2: geometry products, registered inside the filter.
	crh_pkg::geo_t geo_s2;

	crh_filter u_filter (
		.clk    (clk),
		.load   (mv1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.geo_s2 (geo_s2)
	);

	// Stage 2 decode: radius test, bin clamp and the histogram read address.
	// A zero bin count behaves as one bin, and a count above the store size
	// behaves as the store size.
	logic [40:0]       r2_s2;
	logic [31:0]       nb;
	logic [31:0]       last_bin;
	logic [31:0]       bin_raw;
	logic [31:0]       bin_sel;
	logic [31:0]       rb_wide;
	logic              is_read_s2;
	logic [AW-1:0]     raddr_s2;
	crh_pkg::upd_ctl_t ctl_s2;

	always_comb begin
		if (cfg_q.bins_used == 9'd0) begin
			nb = 32'd1;
		end else if (32'(cfg_q.bins_used) > 32'(MAX_BINS)) begin
			nb = 32'(MAX_BINS);
		end else begin
			nb = 32'(cfg_q.bins_used);
		end
		last_bin = nb - 32'd1;
		bin_raw = 32'(geo_s2.prod[51:24]);
		bin_sel = (bin_raw > last_bin) ? last_bin : bin_raw;
		r2_s2 = 41'(geo_s2.sq_x) + 41'(geo_s2.sq_y);
		rb_wide = 32'(geo_s2.read_bin);
		is_read_s2 = (geo_s2.func == crh_pkg::FUNC_READ);

		ctl_s2.is_read = is_read_s2;
		ctl_s2.hit = !is_read_s2 && geo_s2.z_in && (43'(r2_s2) <= cfg_q.radius_sq);
		ctl_s2.oob = rb_wide >= 32'(MAX_BINS);
		if (is_read_s2) begin
			ctl_s2.bin_hit = geo_s2.read_bin;
		end else begin
			ctl_s2.bin_hit = ctl_s2.hit ? bin_sel[7:0] : 8'd0;
		end
		raddr_s2 = is_read_s2 ? rb_wide[AW-1:0] : bin_sel[AW-1:0];
	end

	// Stage 3: memory read data arrives with the item.
	crh_pkg::upd_ctl_t ctl_s3;
	logic [AW-1:0]     addr_s3;

	always_ff @(posedge clk) begin
		if (mv2) begin
			ctl_s3  <= ctl_s2;
			addr_s3 <= raddr_s2;
		end
	end

	logic          upd_we;
	logic [AW-1:0] upd_waddr;
	logic [31:0]   upd_wdata;
	logic [31:0]   ram_rdata;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;

	// The clearing pass owns the write port until it is done.
	always_comb begin
		ram_we    = clr_active_q || upd_we;
		ram_waddr = clr_active_q ? clr_idx_q : upd_waddr;
		ram_wdata = clr_active_q ? 32'd0 : upd_wdata;
	end

	crh_ram #(
		.WIDTH (32),
		.DEPTH (MAX_BINS)
	) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (mv2),
		.raddr (raddr_s2),
		.rdata (ram_rdata)
	);

	crh_update #(
		.AW (AW)
	) u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (adv3),
		.ctl         (ctl_s3),
		.addr        (addr_s3),
		.rd_data     (ram_rdata),
		.we          (upd_we),
		.waddr       (upd_waddr),
		.wdata       (upd_wdata),
		.in_region   (in_region),
		.bin_hit     (bin_hit),
		.count_value (count_value)
	);

	// Item updates never collide with the clearing pass.
	`CRH_ASSERT(a_no_update_in_clear, upd_we, !clr_active_q, "histogram update during clear")
	// No item is anywhere in the pipeline while the memory is being cleared.
	`CRH_ASSERT(a_pipe_empty_in_clear, clr_active_q, !pipe_busy, "item in flight during clear")
	// A counted position always reports a count of at least one.
	`CRH_ASSERT(a_hit_count_nonzero, out_valid_q && in_region, |count_value, "zero count on hit")
	// A stalled update stage keeps its item and address.
	`CRH_ASSERT_NEXT(a_s3_holds, !en3, valid_s3 && $stable(addr_s3), "update stage lost item")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cylinder_region_histogram. Position and read items
// go in over a valid/ready channel while a shadow histogram predicts every
// result. Directed items cover the region bounds, the field extremes and the
// bin clamping. Randomized phases with fresh register settings follow.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MAX_BINS = 256;
	localparam int RESET_CYCLES = 7;
	// This covers the pipeline from the accepting edge to the result. Allow some
	// slack on top.
	localparam int PIPE_CYCLES = 8;
	// The slowest legal run is well under this, even with the longest gaps and
	// stalls on every item and the clearing pass after reset.
	localparam longint CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 215;
	localparam int TAIL_ITEMS = 130;
	// The reset radius_sq is exactly this value squared.
	localparam longint RST_RADIUS = 3797;

	typedef logic [crh_pkg::CFG_DW-1:0] cfg_word_t;
	typedef logic [crh_pkg::CFG_AW-1:0] cfg_idx_t;

	// Index 7 has no register behind it. Writes to it must change nothing.
	localparam cfg_idx_t REG_NONE = 3'd7;

	typedef struct packed {
		logic        in_region;
		logic [7:0]  bin_hit;
		logic [31:0] count_value;
	} hist_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	cfg_idx_t            cfg_addr;
	cfg_word_t           cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic                func;
	logic signed [19:0]  pos_x;
	logic signed [19:0]  pos_y;
	logic signed [19:0]  pos_z;
	logic [7:0]          read_bin;
	logic                out_valid;
	logic                out_ready;
	logic                in_region;
	logic [7:0]          bin_hit;
	logic [31:0]         count_value;

	// The shadow copy of the block's registers and of its histogram memory.
	crh_pkg::cfg_t       shadow_cfg;
	logic [31:0]         shadow_counts [MAX_BINS];
	// These are the predicted results, oldest first. They are pushed when an
	// item is accepted.
	hist_result_t        due_results [$];

	int                  mismatch_count = 0;
	longint              cycle_count = 0;
	// These enable random idle bursts on both channels.
	bit                  gaps_on = 1'b0;
	int                  stall_left = 0;
	// This is the half width of the box that targeted positions are drawn from.
	longint              aim_radius = 0;

	cylinder_region_histogram #(
		.MAX_BINS(MAX_BINS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.read_bin(read_bin),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.in_region(in_region),
		.bin_hit(bin_hit),
		.count_value(count_value)
	);

	always #5 clk = ~clk;

	// This watchdog ends a run that hangs, for example when a result never
	// arrives.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// The receiver stalls out_ready in random bursts while gaps are enabled.
	// Otherwise it is always ready.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 14);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic longint as_signed20(logic [19:0] v);
		return longint'($signed(v));
	endfunction

	function automatic logic [19:0] clip20(longint v);
		if (v > 524287)
			return 20'h7FFFF;
		if (v < -524288)
			return 20'h80000;
		return v[19:0];
	endfunction

	function automatic longint spread(longint r);
		return longint'($urandom_range(0, 32'(2 * r))) - r;
	endfunction

	// This puts random bits above the register width. The block must drop them.
	function automatic cfg_word_t with_junk(cfg_word_t value, int width);
		cfg_word_t junk;
		junk = cfg_word_t'({$urandom, $urandom});
		junk = junk << width;
		return junk | (value & ((cfg_word_t'(1) << width) - cfg_word_t'(1)));
	endfunction

	// Each register keeps only its own width of the written data.
	function automatic void apply_reg(cfg_idx_t idx, cfg_word_t data);
		case (idx)
			crh_pkg::REG_LOW_Z:     shadow_cfg.low_z = data[19:0];
			crh_pkg::REG_UP_Z:      shadow_cfg.up_z = data[19:0];
			crh_pkg::REG_CENTER_X:  shadow_cfg.center_x = data[19:0];
			crh_pkg::REG_CENTER_Y:  shadow_cfg.center_y = data[19:0];
			crh_pkg::REG_RADIUS_SQ: shadow_cfg.radius_sq = data[42:0];
			crh_pkg::REG_BIN_SCALE: shadow_cfg.bin_scale = data[31:0];
			crh_pkg::REG_BINS_USED: shadow_cfg.bins_used = data[8:0];
			default: ;
		endcase
	endfunction

	// This predicts the result of one item and updates the shadow histogram.
	function automatic hist_result_t histogram_update(crh_pkg::item_t it);
		hist_result_t res;
		longint       z;
		longint       lz;
		longint       dx;
		longint       dy;
		logic [63:0]  r2;
		logic [63:0]  off;
		logic [63:0]  bin;
		logic [63:0]  last;
		res = '0;
		if (it.func == crh_pkg::FUNC_READ) begin
			res.bin_hit = it.read_bin;
			res.count_value = (it.read_bin < MAX_BINS) ? shadow_counts[it.read_bin] : 32'd0;
			return res;
		end
		z = as_signed20(it.pos_z);
		lz = as_signed20(shadow_cfg.low_z);
		// The slab is closed at low_z and open at up_z.
		if (z < lz || z >= as_signed20(shadow_cfg.up_z))
			return res;
		dx = as_signed20(it.pos_x) - as_signed20(shadow_cfg.center_x);
		dy = as_signed20(it.pos_y) - as_signed20(shadow_cfg.center_y);
		r2 = dx * dx + dy * dy;
		if (r2 > {21'd0, shadow_cfg.radius_sq})
			return res;
		off = z - lz;
		bin = (off * {32'd0, shadow_cfg.bin_scale}) >> 24;
		// A bins_used of zero acts as one bin. Values above the store size act
		// as the full store.
		if (shadow_cfg.bins_used == 9'd0)
			last = 64'd0;
		else if (shadow_cfg.bins_used > MAX_BINS)
			last = 64'(MAX_BINS - 1);
		else
			last = 64'(shadow_cfg.bins_used) - 64'd1;
		if (bin > last)
			bin = last;
		if (shadow_counts[bin[7:0]] != 32'hFFFFFFFF)
			shadow_counts[bin[7:0]] = shadow_counts[bin[7:0]] + 32'd1;
		res.in_region = 1'b1;
		res.bin_hit = bin[7:0];
		res.count_value = shadow_counts[bin[7:0]];
		return res;
	endfunction

	// This sends one item. It may idle first. Valid is raised at a falling edge
	// and stays up until a rising edge sees ready. The prediction is made at
	// acceptance.
	task automatic send_item(crh_pkg::item_t it);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= it.func;
		pos_x <= it.pos_x;
		pos_y <= it.pos_y;
		pos_z <= it.pos_z;
		read_bin <= it.read_bin;
		do @(posedge clk); while (!in_ready);
		due_results.push_back(histogram_update(it));
	endtask

	task automatic send_accum(longint x, longint y, longint z);
		crh_pkg::item_t it;
		it.func = crh_pkg::FUNC_ACCUM;
		it.pos_x = clip20(x);
		it.pos_y = clip20(y);
		it.pos_z = clip20(z);
		it.read_bin = 8'($urandom);
		send_item(it);
	endtask

	task automatic send_read(logic [7:0] idx);
		crh_pkg::item_t it;
		it.func = crh_pkg::FUNC_READ;
		it.pos_x = 20'($urandom);
		it.pos_y = 20'($urandom);
		it.pos_z = 20'($urandom);
		it.read_bin = idx;
		send_item(it);
	endtask

	// This drops valid and waits until every predicted result has come back.
	// The block is idle afterwards, so registers may change.
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_word_t data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, data);
	endtask

	// This picks a random slab and cylinder and a bin scale that spreads the
	// slab over the bins in use. Sometimes it uses a huge radius, an odd bin
	// count or a random scale.
	task automatic setup_random_region();
		longint span;
		longint lz;
		longint cx;
		longint cy;
		longint rsq;
		longint nb;
		longint eff;
		longint scale;
		if ($urandom_range(0, 4) == 0)
			span = longint'($urandom_range(1, 64));
		else
			span = longint'($urandom_range(100, 60000));
		lz = longint'($urandom_range(0, 1048575)) - 524288;
		if (lz + span > 524287)
			lz = 524287 - span;
		cx = longint'($urandom_range(0, 1048575)) - 524288;
		cy = longint'($urandom_range(0, 1048575)) - 524288;
		if ($urandom_range(0, 7) == 0) begin
			rsq = (longint'($urandom_range(0, 2047)) << 32) | longint'($urandom);
			aim_radius = 524287;
		end else begin
			aim_radius = longint'($urandom_range(0, 5000));
			rsq = aim_radius * aim_radius + longint'($urandom_range(0, 32'(aim_radius)));
		end
		case ($urandom_range(0, 9))
			0: nb = 0;
			1: nb = longint'($urandom_range(257, 511));
			default: nb = longint'($urandom_range(1, 256));
		endcase
		eff = (nb == 0) ? 1 : (nb > MAX_BINS) ? MAX_BINS : nb;
		scale = ((eff << 24) / span) * longint'($urandom_range(80, 130)) / 100;
		if (scale > 64'hFFFFFFFF || $urandom_range(0, 9) == 0)
			scale = longint'($urandom);
		write_reg(crh_pkg::REG_LOW_Z, with_junk(cfg_word_t'(lz), 20));
		write_reg(crh_pkg::REG_UP_Z, with_junk(cfg_word_t'(lz + span), 20));
		write_reg(crh_pkg::REG_CENTER_X, with_junk(cfg_word_t'(cx), 20));
		write_reg(crh_pkg::REG_CENTER_Y, with_junk(cfg_word_t'(cy), 20));
		write_reg(crh_pkg::REG_RADIUS_SQ, cfg_word_t'(rsq));
		write_reg(crh_pkg::REG_BIN_SCALE, with_junk(cfg_word_t'(scale), 32));
		write_reg(crh_pkg::REG_BINS_USED, with_junk(cfg_word_t'(nb), 9));
	endtask

	// Most items are positions aimed into the current region, some near the z
	// bounds. The rest are bin reads and unaimed noise positions.
	function automatic crh_pkg::item_t random_item();
		crh_pkg::item_t it;
		int             pick;
		longint         lz;
		longint         uz;
		it.func = crh_pkg::FUNC_ACCUM;
		it.pos_x = 20'($urandom);
		it.pos_y = 20'($urandom);
		it.pos_z = 20'($urandom);
		it.read_bin = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			it.func = crh_pkg::FUNC_READ;
		end else begin
			it.func = crh_pkg::FUNC_ACCUM;
			if (pick >= 25) begin
				lz = as_signed20(shadow_cfg.low_z);
				uz = as_signed20(shadow_cfg.up_z);
				it.pos_x = clip20(as_signed20(shadow_cfg.center_x) + spread(aim_radius));
				it.pos_y = clip20(as_signed20(shadow_cfg.center_y) + spread(aim_radius));
				if (uz > lz)
					it.pos_z = clip20(lz + longint'($urandom_range(0, 32'(uz - lz - 1))));
				case (pick)
					96: it.pos_z = clip20(lz);
					97: it.pos_z = clip20(uz - 1);
					98: it.pos_z = clip20(uz);
					99: it.pos_z = clip20(lz - 1);
					default: ;
				endcase
			end
		end
		return it;
	endfunction

	// This test runs with the reset settings. It reads the cleared store, then
	// sends positions on both z bounds, just outside them, and on and just past the radius.
	task automatic test_reset_defaults();
		longint cx;
		longint cy;
		longint lz;
		longint uz;
		cx = as_signed20(shadow_cfg.center_x);
		cy = as_signed20(shadow_cfg.center_y);
		lz = as_signed20(shadow_cfg.low_z);
		uz = as_signed20(shadow_cfg.up_z);
		send_read(8'd0);
		send_read(8'd255);
		send_accum(cx, cy, lz);
		send_accum(cx, cy, uz - 1);
		send_accum(cx, cy, uz);
		send_accum(cx, cy, lz - 1);
		send_accum(cx + RST_RADIUS, cy, lz + 100);
		send_accum(cx + RST_RADIUS + 1, cy, lz + 100);
		send_accum(cx, cy - RST_RADIUS, lz);
		send_read(8'd0);
	endtask

	// This test uses the widest slab and the farthest corners. A maximal scale
	// clamps to the last bin. Then it uses a zero radius, a zero scale and a
	// bins_used of zero.
	task automatic test_field_extremes();
		wait_drain();
		write_reg(crh_pkg::REG_LOW_Z, cfg_word_t'(-524288));
		write_reg(crh_pkg::REG_UP_Z, cfg_word_t'(524287));
		write_reg(crh_pkg::REG_CENTER_X, cfg_word_t'(524287));
		write_reg(crh_pkg::REG_CENTER_Y, cfg_word_t'(-524288));
		write_reg(crh_pkg::REG_RADIUS_SQ, 43'h400_0000_0000);
		write_reg(crh_pkg::REG_BIN_SCALE, cfg_word_t'(32'hFFFF_FFFF));
		write_reg(crh_pkg::REG_BINS_USED, cfg_word_t'(9'h1FF));
		send_accum(-524288, 524287, 524286);
		send_accum(-524288, 524287, -524288);
		send_accum(524287, -524288, 524287);
		send_read(8'd255);
		wait_drain();
		write_reg(crh_pkg::REG_CENTER_X, '0);
		write_reg(crh_pkg::REG_CENTER_Y, '0);
		write_reg(crh_pkg::REG_RADIUS_SQ, '0);
		write_reg(crh_pkg::REG_BIN_SCALE, '0);
		write_reg(crh_pkg::REG_BINS_USED, '0);
		send_accum(0, 0, 1000);
		send_accum(1, 0, 1000);
		send_accum(0, -1, 524286);
		wait_drain();
		// This write has no register behind it. The read after it must still
		// see the same setup.
		write_reg(REG_NONE, cfg_word_t'({$urandom, $urandom}));
		send_read(8'd0);
	endtask

	// This test fills a high bin and then lowers bins_used. The count stays
	// readable, and new hits clamp to the new last bin. An inverted slab
	// accepts nothing.
	task automatic test_bins_used_lowered();
		wait_drain();
		write_reg(crh_pkg::REG_LOW_Z, '0);
		write_reg(crh_pkg::REG_UP_Z, cfg_word_t'(1000));
		write_reg(crh_pkg::REG_RADIUS_SQ, 43'h400_0000_0000);
		write_reg(crh_pkg::REG_BIN_SCALE, cfg_word_t'(32'h0100_0000));
		write_reg(crh_pkg::REG_BINS_USED, cfg_word_t'(256));
		send_accum(5, -5, 200);
		send_accum(0, 0, 200);
		send_accum(0, 0, 7);
		wait_drain();
		write_reg(crh_pkg::REG_BINS_USED, cfg_word_t'(8));
		send_read(8'd200);
		send_accum(0, 0, 200);
		send_read(8'd7);
		wait_drain();
		write_reg(crh_pkg::REG_LOW_Z, cfg_word_t'(500));
		write_reg(crh_pkg::REG_UP_Z, cfg_word_t'(-500));
		send_accum(0, 0, 0);
		send_accum(0, 0, 500);
	endtask

	// This test runs randomized phases, each with a new register setup. Some
	// phases have no idling. The sender sometimes waits for every result
	// before it goes on, and it always does so halfway through each phase.
	task automatic test_random_phases();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drain();
			gaps_on = (p % 4 != 3);
			setup_random_region();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2 || $urandom_range(0, 149) == 0)
					wait_drain();
				send_item(random_item());
			end
		end
	endtask

	// The final stretch runs at full rate with no idling on either side.
	task automatic test_full_rate_tail();
		gaps_on = 1'b0;
		wait_drain();
		setup_random_region();
		for (int n = 0; n < TAIL_ITEMS; n++)
			send_item(random_item());
	endtask

	// This compares each accepted result, field by field, with the oldest
	// prediction.
	always @(posedge clk) begin : result_check
		hist_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result with none expected: in_region %0b bin %0d count %0d",
					in_region, bin_hit, count_value));
			end else begin
				want = due_results.pop_front();
				if (in_region !== want.in_region)
					report_mismatch($sformatf("in_region %0b, want %0b", in_region, want.in_region));
				if (bin_hit !== want.bin_hit)
					report_mismatch($sformatf("bin_hit %0d, want %0d", bin_hit, want.bin_hit));
				if (count_value !== want.count_value)
					report_mismatch($sformatf("count_value %0d, want %0d (bin %0d)",
						count_value, want.count_value, want.bin_hit));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		func = crh_pkg::FUNC_ACCUM;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		read_bin = '0;
		out_ready = 1'b1;
		shadow_cfg = '{low_z: crh_pkg::RST_LOW_Z, up_z: crh_pkg::RST_UP_Z,
			center_x: crh_pkg::RST_CENTER_X, center_y: crh_pkg::RST_CENTER_Y,
			radius_sq: crh_pkg::RST_RADIUS_SQ, bin_scale: crh_pkg::RST_BIN_SCALE,
			bins_used: crh_pkg::RST_BINS_USED};
		foreach (shadow_counts[i])
			shadow_counts[i] = 32'd0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// The clearing pass after reset holds in_ready low. The sender just
		// waits on the handshake.
		gaps_on = 1'b1;
		test_reset_defaults();
		test_field_extremes();
		test_bins_used_lowered();
		test_random_phases();
		test_full_rate_tail();
		wait_drain();
		repeat (PIPE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
